[rtl/ihex_pkg.sv]
`timescale 1ns / 1ps

package ihex_pkg;

   // Data records hold at most this many bytes and never cross a boundary of this size.
   localparam int RecordBytes = 16;
   localparam int RecIdxW     = $clog2(RecordBytes);
   localparam int RecLenW     = RecIdxW + 1;

   localparam logic [7:0] CharColon   = 8'h3A;
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharAlpha   = 8'h37;

   localparam logic [7:0] RecTypeData = 8'h00;
   localparam logic [7:0] RecTypeEof  = 8'h01;
   localparam logic [7:0] RecTypeExt  = 8'h04;
   localparam logic [7:0] ExtByteCnt  = 8'h02;
   localparam logic [7:0] EofCsum     = 8'hFF;

   localparam logic CsrStartAddress = 1'b0;
   localparam logic CsrTotalLength  = 1'b1;

   // Pieces of text that one input byte can cause, in output order.
   typedef enum logic [2:0] {
      SEG_EXT_PRE  = 3'd0,
      SEG_OPEN     = 3'd1,
      SEG_DATA     = 3'd2,
      SEG_CLOSE    = 3'd3,
      SEG_EXT_POST = 3'd4,
      SEG_EOF      = 3'd5,
      SEG_NONE     = 3'd6
   } seg_type;

   typedef struct packed {
      logic        has_pre;
      logic        has_open;
      logic        has_data;
      logic        has_close;
      logic        has_post;
      logic        has_eof;
      logic [15:0] pre_upper;
      logic [7:0]  rec_len;
      logic [15:0] rec_addr;
      logic [7:0]  data;
      logic [7:0]  rec_csum;
      logic [15:0] post_upper;
   } cmd_type;

   function automatic logic [5:0] seg_enables(input cmd_type c);
      return {c.has_eof, c.has_post, c.has_close, c.has_data, c.has_open, c.has_pre};
   endfunction

   // Lowest enabled piece at or after the given position.
   function automatic seg_type first_seg(input logic [5:0] en, input logic [2:0] from);
      seg_type r;
      r = SEG_NONE;
      for (int k = 5; k >= 0; k--) begin
         if (en[k] && (3'(k) >= from)) begin
            r = seg_type'(3'(k));
         end
      end
      return r;
   endfunction

   function automatic logic [4:0] seg_last(input seg_type s);
      logic [4:0] r;
      case (s)
         SEG_EXT_PRE, SEG_EXT_POST: r = 5'd15;
         SEG_OPEN:                  r = 5'd8;
         SEG_DATA:                  r = 5'd1;
         SEG_CLOSE:                 r = 5'd2;
         SEG_EOF:                   r = 5'd11;
         default:                   r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (CharZero + 8'(n)) : (CharAlpha + 8'(n));
   endfunction

endpackage

[rtl/ihex_front.sv]
`timescale 1ns / 1ps

module ihex_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   output logic                cmd_push,
   output ihex_pkg::cmd_type   cmd
);

   logic [31:0] start_address_ff;
   logic [31:0] total_length_ff;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [ihex_pkg::RecLenW-1:0] left_ff, left_in;
   logic [7:0]  sum_ff, sum_in;
   logic        started_ff, started_in;
   logic        finished_ff, finished_in;

   logic [31:0] addr_cur;
   logic [31:0] rem_cur;
   logic [ihex_pkg::RecLenW-1:0] left_cur;
   logic [7:0]  sum_cur;
   logic [ihex_pkg::RecLenW-1:0] len_blk;
   logic [ihex_pkg::RecLenW-1:0] len_a;
   logic [ihex_pkg::RecLenW-1:0] len;
   logic [16:0] to64k;
   logic [ihex_pkg::RecLenW-1:0] left_open;
   logic [ihex_pkg::RecLenW-1:0] left_after;
   logic [7:0]  sum_open;
   logic [7:0]  sum_after;
   logic [31:0] addr_next;
   logic [31:0] rem_next;
   logic        rem_zero;
   logic        open_rec;
   logic        close_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= 32'd0;
         total_length_ff  <= 32'd1;
      end else if (csr_we) begin
         case (csr_index)
            ihex_pkg::CsrStartAddress: start_address_ff <= csr_wdata;
            ihex_pkg::CsrTotalLength:  total_length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      addr_cur = started_ff ? addr_ff : start_address_ff;
      rem_cur  = started_ff ? remaining_ff : total_length_ff;
      left_cur = started_ff ? left_ff : '0;
      sum_cur  = started_ff ? sum_ff : 8'd0;
      rem_zero = (rem_cur == 32'd0);

      // Record length: up to the next record boundary, the next 64 KiB boundary
      // and the end of the data, whichever comes first.
      len_blk = ihex_pkg::RecLenW'(ihex_pkg::RecordBytes)
              - {1'b0, addr_cur[ihex_pkg::RecIdxW-1:0]};
      to64k   = 17'h10000 - {1'b0, addr_cur[15:0]};
      len_a   = (to64k < 17'(len_blk)) ? to64k[ihex_pkg::RecLenW-1:0] : len_blk;
      len     = (rem_cur < 32'(len_a)) ? rem_cur[ihex_pkg::RecLenW-1:0] : len_a;

      open_rec   = (left_cur == '0);
      left_open  = open_rec ? len : left_cur;
      sum_open   = open_rec ? (8'(len) + addr_cur[15:8] + addr_cur[7:0]) : sum_cur;
      sum_after  = sum_open + data_byte;
      left_after = left_open - 1'b1;
      close_rec  = (left_after == '0);
      addr_next  = addr_cur + 32'd1;
      rem_next   = rem_cur - 32'd1;

      cmd.has_pre    = !started_ff;
      cmd.has_open   = !rem_zero && open_rec;
      cmd.has_data   = !rem_zero;
      cmd.has_close  = !rem_zero && close_rec;
      cmd.has_post   = !rem_zero && close_rec && (addr_next[15:0] == 16'd0);
      cmd.has_eof    = rem_zero || (close_rec && (rem_next == 32'd0));
      cmd.pre_upper  = addr_cur[31:16];
      cmd.rec_len    = 8'(len);
      cmd.rec_addr   = addr_cur[15:0];
      cmd.data       = data_byte;
      cmd.rec_csum   = 8'd0 - sum_after;
      cmd.post_upper = addr_next[31:16];

      cmd_push = accept && !finished_ff;

      addr_in      = addr_ff;
      remaining_in = remaining_ff;
      left_in      = left_ff;
      sum_in       = sum_ff;
      started_in   = started_ff;
      finished_in  = finished_ff;
      if (cmd_push) begin
         started_in  = 1'b1;
         finished_in = cmd.has_eof;
         if (!rem_zero) begin
            addr_in      = addr_next;
            remaining_in = rem_next;
            left_in      = left_after;
            sum_in       = close_rec ? 8'd0 : sum_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= 32'd0;
         remaining_ff <= 32'd0;
         left_ff      <= '0;
         sum_ff       <= 8'd0;
         started_ff   <= 1'b0;
         finished_ff  <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         remaining_ff <= remaining_in;
         left_ff      <= left_in;
         sum_ff       <= sum_in;
         started_ff   <= started_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

[rtl/ihex_cmd_fifo.sv]
`timescale 1ns / 1ps

module ihex_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ihex_pkg::cmd_type   wdata,
   output logic                full,
   input  logic                pop,
   output ihex_pkg::cmd_type   rdata,
   output logic                empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ihex_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/ihex_back.sv]
`timescale 1ns / 1ps

module ihex_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  ihex_pkg::cmd_type   q_data,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          text_char,
   output logic                run_last,
   output logic                stream_done
);

   ihex_pkg::cmd_type cmd_ff, cmd_in;
   ihex_pkg::seg_type seg_ff, seg_in;
   ihex_pkg::seg_type seg_nxt;
   logic [4:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       done_ff;

   logic       seg_end;
   logic       item_end;
   logic       advance;
   logic       load;
   logic       colon_seg;
   logic [4:0] hex_pos;
   logic [3:0] byte_sel;
   logic [15:0] upper;
   logic [7:0] ext_csum;
   logic [7:0] cur_byte;
   logic [7:0] cur_char;

   // Character generator for the current piece and position.
   always_comb begin
      colon_seg = (seg_ff == ihex_pkg::SEG_EXT_PRE) || (seg_ff == ihex_pkg::SEG_EXT_POST)
               || (seg_ff == ihex_pkg::SEG_OPEN) || (seg_ff == ihex_pkg::SEG_EOF);
      hex_pos  = colon_seg ? (idx_ff - 5'd1) : idx_ff;
      byte_sel = hex_pos[4:1];
      upper    = (seg_ff == ihex_pkg::SEG_EXT_PRE) ? cmd_ff.pre_upper : cmd_ff.post_upper;
      ext_csum = 8'd0 - (ihex_pkg::ExtByteCnt + ihex_pkg::RecTypeExt + upper[15:8]
                         + upper[7:0]);

      cur_byte = 8'd0;
      case (seg_ff)
         ihex_pkg::SEG_EXT_PRE, ihex_pkg::SEG_EXT_POST: begin
            case (byte_sel)
               4'd0:    cur_byte = ihex_pkg::ExtByteCnt;
               4'd3:    cur_byte = ihex_pkg::RecTypeExt;
               4'd4:    cur_byte = upper[15:8];
               4'd5:    cur_byte = upper[7:0];
               4'd6:    cur_byte = ext_csum;
               default: cur_byte = 8'd0;
            endcase
         end
         ihex_pkg::SEG_OPEN: begin
            case (byte_sel)
               4'd0:    cur_byte = cmd_ff.rec_len;
               4'd1:    cur_byte = cmd_ff.rec_addr[15:8];
               4'd2:    cur_byte = cmd_ff.rec_addr[7:0];
               default: cur_byte = ihex_pkg::RecTypeData;
            endcase
         end
         ihex_pkg::SEG_DATA:  cur_byte = cmd_ff.data;
         ihex_pkg::SEG_CLOSE: cur_byte = cmd_ff.rec_csum;
         ihex_pkg::SEG_EOF: begin
            case (byte_sel)
               4'd3:    cur_byte = ihex_pkg::RecTypeEof;
               4'd4:    cur_byte = ihex_pkg::EofCsum;
               default: cur_byte = 8'd0;
            endcase
         end
         default: cur_byte = 8'd0;
      endcase

      seg_end = (idx_ff == ihex_pkg::seg_last(seg_ff));
      if (colon_seg && (idx_ff == 5'd0)) begin
         cur_char = ihex_pkg::CharColon;
      end else if (seg_end && (seg_ff != ihex_pkg::SEG_OPEN)
                   && (seg_ff != ihex_pkg::SEG_DATA)) begin
         cur_char = ihex_pkg::CharNewline;
      end else begin
         cur_char = ihex_pkg::hex_char(hex_pos[0] ? cur_byte[3:0] : cur_byte[7:4]);
      end
   end

   // Sequencer: walks the enabled pieces of one word, then takes the next word.
   always_comb begin
      seg_nxt  = ihex_pkg::first_seg(ihex_pkg::seg_enables(cmd_ff), 3'(seg_ff) + 3'd1);
      item_end = seg_end && (seg_nxt == ihex_pkg::SEG_NONE);
      advance  = busy_ff && (!out_valid_ff || pop);
      load     = !q_empty && (!busy_ff || (advance && item_end));
      q_pop    = load;

      cmd_in  = cmd_ff;
      seg_in  = seg_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         cmd_in  = q_data;
         seg_in  = ihex_pkg::first_seg(ihex_pkg::seg_enables(q_data), 3'd0);
         idx_in  = 5'd0;
         busy_in = 1'b1;
      end else if (advance) begin
         if (!seg_end) begin
            idx_in = idx_ff + 5'd1;
         end else if (item_end) begin
            busy_in = 1'b0;
            seg_in  = ihex_pkg::SEG_NONE;
            idx_in  = 5'd0;
         end else begin
            seg_in = seg_nxt;
            idx_in = 5'd0;
         end
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (advance) begin
         char_ff <= cur_char;
         last_ff <= item_end;
         done_ff <= seg_end && (seg_ff == ihex_pkg::SEG_EOF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= ihex_pkg::SEG_NONE;
         idx_ff       <= 5'd0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty       = !out_valid_ff;
   assign text_char   = char_ff;
   assign run_last    = last_ff;
   assign stream_done = done_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && done_ff |-> last_ff && (char_ff == ihex_pkg::CharNewline))
      else $error("end of stream not on the final newline of a word");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (seg_ff != ihex_pkg::SEG_NONE) && (idx_ff <= ihex_pkg::seg_last(seg_ff)))
      else $error("sequencer position out of range");

   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> seg_ff == ihex_pkg::SEG_NONE)
      else $error("idle sequencer holds a piece");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !pop |=> out_valid_ff && $stable(char_ff) && $stable(last_ff))
      else $error("waiting character changed");

endmodule

[rtl/intel_hex_record_encoder.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req       in         push / full        req_data_byte (8)
// rsp       out        empty / pop        rsp_text_char (8), rsp_run_last, rsp_stream_done
// csr       in         csr_we             csr_index (1), csr_wdata (32)
//
// Each input byte yields up to 58 characters, none once the end record is out, about 3
// on average with 16-byte records. The back sequencer sends one character per cycle while
// the queue keeps it fed and pop does not stall it; after the queue runs dry it loads
// the next word before sending its first character. The character count sets the rate.
// The front takes a byte per cycle while the command queue has room (QUEUE_DEPTH words).
// Synchronous active-high reset clears the stream state; registers return to
// start address 0 and total length 1. A stalled pop holds the output register and,
// once the queue fills, raises full.

module intel_hex_record_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_run_last,
   output logic        rsp_stream_done,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   ihex_pkg::cmd_type front_cmd;
   ihex_pkg::cmd_type q_data;
   logic              front_push;
   logic              q_empty;
   logic              q_pop;

   ihex_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (push && !full),
      .data_byte (req_data_byte),
      .cmd_push  (front_push),
      .cmd       (front_cmd)
   );

   ihex_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_cmd),
      .full  (full),
      .pop   (q_pop),
      .rdata (q_data),
      .empty (q_empty)
   );

   ihex_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .empty       (empty),
      .pop         (pop),
      .text_char   (rsp_text_char),
      .run_last    (rsp_run_last),
      .stream_done (rsp_stream_done)
   );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int StreamBytes = 450;
   localparam int PhaseBytes  = 112;
   localparam int StrayBytes  = 6;
   localparam int HoldCycles  = 300;
   localparam int DrainCycles = 60;
   localparam int CycleLimit  = 200000;

   typedef struct packed {
      logic [7:0] text_char;
      logic       run_last;
      logic       stream_done;
   } text_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_text_char;
   logic        rsp_run_last;
   logic        rsp_stream_done;
   logic        csr_we = 1'b0;
   logic        csr_index = ihex_pkg::CsrStartAddress;
   logic [31:0] csr_wdata = '0;

   // Encoder state as the testbench tracks it.
   logic [31:0] cfg_start_address = '0;
   logic [31:0] cfg_total_length = 32'd1;
   logic [31:0] next_address = '0;
   logic [31:0] bytes_left = '0;
   logic [7:0]  record_left = '0;
   logic [7:0]  record_sum = '0;
   logic        stream_started = 1'b0;
   logic        stream_finished = 1'b0;

   logic [7:0]     pending_bytes[$];
   text_word_type  expected_text[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_request = 1'b0;
   int hold_left = 0;
   int fail_count = 0;
   int bytes_sent = 0;
   int chars_seen = 0;
   int cycle_count = 0;
   logic [31:0] stream_base;

   intel_hex_record_encoder dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data_byte(req_data_byte),
      .empty(empty),
      .pop(pop),
      .rsp_text_char(rsp_text_char),
      .rsp_run_last(rsp_run_last),
      .rsp_stream_done(rsp_stream_done),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [7:0] hex_ascii(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
   endfunction

   task automatic emit_char(input logic [7:0] ch, input logic done);
      text_word_type w;
      w.text_char = ch;
      w.run_last = 1'b0;
      w.stream_done = done;
      expected_text.push_back(w);
   endtask

   task automatic emit_hex(input logic [7:0] v);
      emit_char(hex_ascii(v[7:4]), 1'b0);
      emit_char(hex_ascii(v[3:0]), 1'b0);
   endtask

   task automatic emit_ext_record();
      logic [7:0] hi;
      logic [7:0] lo;
      hi = next_address[31:24];
      lo = next_address[23:16];
      emit_char(ihex_pkg::CharColon, 1'b0);
      emit_hex(ihex_pkg::ExtByteCnt);
      emit_hex(8'h00);
      emit_hex(8'h00);
      emit_hex(ihex_pkg::RecTypeExt);
      emit_hex(hi);
      emit_hex(lo);
      emit_hex(8'h00 - (ihex_pkg::ExtByteCnt + ihex_pkg::RecTypeExt + hi + lo));
      emit_char(ihex_pkg::CharNewline, 1'b0);
   endtask

   task automatic emit_end_record();
      emit_char(ihex_pkg::CharColon, 1'b0);
      emit_hex(8'h00);
      emit_hex(8'h00);
      emit_hex(8'h00);
      emit_hex(ihex_pkg::RecTypeEof);
      emit_hex(ihex_pkg::EofCsum);
      emit_char(ihex_pkg::CharNewline, 1'b1);
      stream_finished = 1'b1;
   endtask

   // Appends the characters that one input byte produces.
   task automatic encode_byte(input logic [7:0] b);
      int first;
      logic [31:0] len;
      logic [31:0] to_boundary;
      first = expected_text.size();
      if (!stream_finished) begin
         if (!stream_started) begin
            stream_started = 1'b1;
            next_address = cfg_start_address;
            bytes_left = cfg_total_length;
            record_left = '0;
            record_sum = '0;
            emit_ext_record();
         end
         if (bytes_left == 0) begin
            emit_end_record();
         end else begin
            if (record_left == 0) begin
               // A record stops at the next 16-byte boundary, 64 KiB boundary or data end.
               len = 32'(ihex_pkg::RecordBytes)
                   - (next_address % 32'(ihex_pkg::RecordBytes));
               to_boundary = 32'h0001_0000 - {16'h0000, next_address[15:0]};
               if (to_boundary < len) len = to_boundary;
               if (bytes_left < len) len = bytes_left;
               emit_char(ihex_pkg::CharColon, 1'b0);
               emit_hex(len[7:0]);
               emit_hex(next_address[15:8]);
               emit_hex(next_address[7:0]);
               emit_hex(ihex_pkg::RecTypeData);
               record_sum = len[7:0] + next_address[15:8] + next_address[7:0];
               record_left = len[7:0];
            end
            emit_hex(b);
            record_sum = record_sum + b;
            record_left--;
            bytes_left--;
            next_address++;
            if (record_left == 0) begin
               emit_hex(8'h00 - record_sum);
               emit_char(ihex_pkg::CharNewline, 1'b0);
               record_sum = '0;
               if (next_address[15:0] == 16'h0000) emit_ext_record();
               if (bytes_left == 0) emit_end_record();
            end
         end
      end
      if (expected_text.size() > first) begin
         expected_text[expected_text.size() - 1].run_last = 1'b1;
      end
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == ihex_pkg::CsrStartAddress) cfg_start_address = value;
      else cfg_total_length = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : byte_driver
      logic offer;
      if (reset) begin
         push <= 1'b0;
      end else begin
         offer = push;
         if (push && !full) begin
            encode_byte(req_data_byte);
            void'(pending_bytes.pop_front());
            bytes_sent++;
            offer = 1'b0;
         end
         if (!offer && pending_bytes.size() > 0) begin
            offer = ($urandom_range(0, 99) >= send_idle_pct);
         end
         push <= offer;
         if (offer) req_data_byte <= pending_bytes[0];
      end
   end

   always @(posedge clock) begin : text_monitor
      text_word_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            chars_seen++;
            if (expected_text.size() == 0) begin
               $error("unexpected word: text_char %02h", rsp_text_char);
               fail_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_text_char !== want.text_char) begin
                  $error("text_char: expected %02h, got %02h", want.text_char, rsp_text_char);
                  fail_count++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, rsp_run_last);
                  fail_count++;
               end
               if (rsp_stream_done !== want.stream_done) begin
                  $error("stream_done: expected %0b, got %0b",
                         want.stream_done, rsp_stream_done);
                  fail_count++;
               end
            end
         end
         if (hold_request) begin
            hold_left = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      int queued;
      logic [7:0] directed[$];
      directed = {8'h00, 8'hFF, 8'h01, 8'h10, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD,
                  8'hEF, 8'hFE, 8'h80, 8'h7F, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h9A, 8'hBC};
      queued = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Only the last pair written before the first byte is used by the stream.
      write_register(ihex_pkg::CsrStartAddress, 32'hFFFF_FFFF);
      write_register(ihex_pkg::CsrTotalLength, 32'hFFFF_FFFF);
      write_register(ihex_pkg::CsrStartAddress, 32'h0000_0000);
      write_register(ihex_pkg::CsrTotalLength, 32'd1);
      // Start just below the top so the stream crosses the 4 GiB wrap.
      write_register(ihex_pkg::CsrStartAddress,
                     32'hFFFF_FF00 | 32'($urandom_range(0, 255)));
      write_register(ihex_pkg::CsrTotalLength, 32'(StreamBytes));
      stream_base = cfg_start_address;

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
         endcase
         if (p == 0) begin
            hold_request = 1'b1;
            foreach (directed[i]) pending_bytes.push_back(directed[i]);
            queued = directed.size();
         end
         while (queued < ((p == 3) ? StreamBytes : PhaseBytes * (p + 1))) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
            queued++;
         end
         // Bytes after the end record must be dropped silently.
         if (p == 3) begin
            repeat (StrayBytes) pending_bytes.push_back(8'($urandom_range(0, 255)));
         end
         while (pending_bytes.size() != 0) @(posedge clock);
         while (expected_text.size() != 0) @(posedge clock);
         if (p < 3) begin
            repeat (20) @(posedge clock);
            // Writes in mid-stream are stored but must not disturb the open stream.
            write_register(ihex_pkg::CsrStartAddress, (p == 1) ? 32'hFFFF_FFFF : $urandom);
            write_register(ihex_pkg::CsrTotalLength, (p == 0) ? 32'hFFFF_FFFF : $urandom);
         end
      end
      repeat (DrainCycles) @(posedge clock);

      $display("Encoded %0d data bytes from address %08h into %0d characters,",
               StreamBytes, stream_base, chars_seen);
      $display("across the address wrap, with %0d stray bytes after the end record.",
               bytes_sent - StreamBytes);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/ihex_pkg.sv
rtl/ihex_front.sv
rtl/ihex_cmd_fifo.sv
rtl/ihex_back.sv
rtl/intel_hex_record_encoder.sv
dv/tb_top.sv
